// File: design/bfca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfca_pkg;

	localparam int MAX_CHUNKS = 64;
	localparam int SIZE_BITS  = 32;

	// widths of the fields at the ports
	localparam int INDEX_FIELD_W = 6;
	localparam int SIZE_FIELD_W  = 32;
	localparam int COUNT_FIELD_W = 7;

	localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_ALLOC = 1'b1;

	typedef struct packed {
		logic fits;
		logic take;
	} pick_t;

endpackage

`default_nettype wire

// File: design/best_fit_chunk_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Best-fit chunk allocator.
// Input channel (in_valid / in_stall) carries req_type, chunk_index and amount.
// A load item (req_type 0) writes one chunk size into the table in the cycle
// it is transferred and gives no result; the next item can follow at once.
// An allocate item (req_type 1) walks entries 0 to chunk_count-1 through one
// read port of the table, one entry a cycle, with a single comparator keeping
// the best candidate. After the walk, out_valid rises in the cycle the reduced
// size is written back (the write-back happens only when a fitting entry was
// found). in_stall is high for the whole walk and until the result is
// registered, so a new item is taken only after the last one is through.
// Output channel (out_valid / out_stall) carries found, picked_index and
// left_over from a result register; a pending result holds while out_stall
// is high and a new item may be transferred in the meantime, the next
// allocation waiting at its end until the register frees up.
// chunk_count is written through cfg_valid / cfg_ready while idle.
// Reset (arst_n low) clears chunk_count and marks every table entry as zero
// through per-entry valid bits; no clearing pass is needed.

module best_fit_chunk_allocator
	import bfca_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [COUNT_FIELD_W-1:0] chunk_count,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic                     req_type,
	input  wire logic [INDEX_FIELD_W-1:0] chunk_index,
	input  wire logic [SIZE_FIELD_W-1:0]  amount,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic                          found,
	output logic [INDEX_FIELD_W-1:0]      picked_index,
	output logic [SIZE_FIELD_W-1:0]       left_over
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t                   state_q;
	logic [COUNT_FIELD_W-1:0] count_q;
	logic [MAX_CHUNKS-1:0]    vld_q;

	logic [CNT_W-1:0]         limit_q;
	logic [CNT_W-1:0]         issue_q;
	logic [SIZE_BITS-1:0]     amount_q;
	logic [SIZE_BITS-1:0]     best_q;
	logic [IDX_W-1:0]         best_idx_q;
	logic                     have_q;

	logic                     pend_s1;
	logic                     vld_s1;
	logic [IDX_W-1:0]         idx_s1;

	logic                     out_valid_q;
	logic                     found_q;
	logic [INDEX_FIELD_W-1:0] picked_q;
	logic [SIZE_FIELD_W-1:0]  left_q;

	logic                     in_xfer;
	logic                     ld_ok;
	logic [CNT_W-1:0]         limit_d;
	logic                     issue_go;
	logic                     last;
	logic                     fin_go;
	logic [SIZE_BITS-1:0]     cand;
	logic [SIZE_BITS-1:0]     rest;
	logic [SIZE_BITS-1:0]     rdata;
	logic                     ram_we;
	logic [IDX_W-1:0]         ram_waddr;
	logic [SIZE_BITS-1:0]     ram_wdata;
	pick_t                    pick;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign ld_ok     = (32'(chunk_index) < 32'(MAX_CHUNKS));
	assign limit_d   = (32'(count_q) > 32'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS)
	                                                    : CNT_W'(count_q);

	assign issue_go = (state_q == ST_SCAN) && (issue_q < limit_q);
	assign last     = pend_s1 && ((CNT_W'(idx_s1) + CNT_W'(1)) == limit_q);
	assign fin_go   = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	// entries never written read as zero
	assign cand = vld_s1 ? rdata : '0;
	assign rest = best_q - amount_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = IDX_W'(chunk_index);
		ram_wdata = SIZE_BITS'(amount);
		if (in_xfer && (req_type == REQ_LOAD) && ld_ok) begin
			ram_we = 1'b1;
		end else if (fin_go && have_q) begin
			ram_we    = 1'b1;
			ram_waddr = best_idx_q;
			ram_wdata = rest;
		end
	end

	bfca_ram #(
		.WIDTH(SIZE_BITS),
		.DEPTH(MAX_CHUNKS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (issue_go),
		.raddr(issue_q[IDX_W-1:0]),
		.rdata(rdata)
	);

	bfca_pick u_pick (
		.cand   (cand),
		.request(amount_q),
		.best   (best_q),
		.have   (have_q),
		.pick   (pick)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			vld_q       <= '0;
			issue_q     <= '0;
			limit_q     <= '0;
			amount_q    <= '0;
			best_q      <= '0;
			best_idx_q  <= '0;
			have_q      <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			picked_q    <= '0;
			left_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				count_q <= chunk_count;
			end
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			pend_s1 <= issue_go;
			if (issue_go) begin
				issue_q <= issue_q + CNT_W'(1);
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && (req_type == REQ_ALLOC)) begin
						amount_q <= SIZE_BITS'(amount);
						limit_q  <= limit_d;
						issue_q  <= '0;
						have_q   <= 1'b0;
						state_q  <= (limit_d == '0) ? ST_FIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (pend_s1 && pick.take) begin
						have_q     <= 1'b1;
						best_q     <= cand;
						best_idx_q <= idx_s1;
					end
					if (last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						found_q  <= have_q;
						picked_q <= have_q ? INDEX_FIELD_W'(best_idx_q) : '0;
						left_q   <= have_q ? SIZE_FIELD_W'(rest) : '0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// read pipeline tags, payload only
	always_ff @(posedge clk) begin
		if (issue_go) begin
			idx_s1 <= issue_q[IDX_W-1:0];
			vld_s1 <= vld_q[issue_q[IDX_W-1:0]];
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign picked_index = picked_q;
	assign left_over    = left_q;

endmodule

`default_nettype wire

// File: design/bfca_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bfca_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH)-1:0]         waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic                             re,
	input  wire logic [$clog2(DEPTH)-1:0]         raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: design/bfca_pick.sv
`timescale 1ns / 1ps
`default_nettype none

module bfca_pick
	import bfca_pkg::*;
(
	input  wire logic [SIZE_BITS-1:0] cand,
	input  wire logic [SIZE_BITS-1:0] request,
	input  wire logic [SIZE_BITS-1:0] best,
	input  wire logic                 have,
	output pick_t                     pick
);

	// strict less-than keeps the lowest index on a tie
	always_comb begin
		pick.fits = (cand >= request);
		pick.take = pick.fits && (!have || (cand < best));
	end

endmodule

`default_nettype wire
